[hw/rtl/sru_pkg.sv]
// Shared constants, codes and types of the scaler record unwrapper.
`default_nettype none

package sru_pkg;

    // Field widths of the input and result items.
    localparam int STAMP_W   = 32;
    localparam int FLAGS_W   = 32;
    localparam int SPILL_W   = 16;
    localparam int GROUP_W   = 3;
    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int KIND_W    = 3;
    localparam int CHAN_W    = 5;
    localparam int BIT_W     = 5;
    localparam int CFG_IDX_W = 1;

    // Four channel counters travel in each scaler word, one byte each.
    localparam int LANES  = 4;
    localparam int LANE_W = 2;
    localparam int BYTE_W = 8;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_DELTA = 3'd0,
        KIND_SUM   = 3'd1,
        KIND_REC   = 3'd2,
        KIND_TRIG  = 3'd3,
        KIND_SPILL = 3'd4
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_L1_BIT = 1'b0,
        CFG_SE_BIT = 1'b1
    } t_cfg_idx;

    // One step of the sequencer handed to the merging stage.
    typedef struct packed {
        logic              load;
        t_kind             kind;
        logic [CHAN_W-1:0] channel;
        logic              last;
    } t_step;

endpackage

`default_nettype wire

[hw/rtl/sru_in_if.sv]
// Input channel: one scaler word of a readout record per item.
`default_nettype none

interface sru_in_if;
    import sru_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAMP_W-1:0] stamp;
    logic [FLAGS_W-1:0] trigger_flags;
    logic [SPILL_W-1:0] spill_number;
    logic [GROUP_W-1:0] group_index;
    logic [WORD_W-1:0]  counter_word;
    logic               last_word;

    modport source (
        output valid, stamp, trigger_flags, spill_number, group_index, counter_word,
               last_word,
        input  ready
    );

    modport sink (
        input  valid, stamp, trigger_flags, spill_number, group_index, counter_word,
               last_word,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/sru_out_if.sv]
// Output channel: one decoded scaler result per item.
`default_nettype none

interface sru_out_if;
    import sru_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [CHAN_W-1:0]  channel;
    logic [COUNT_W-1:0] count_value;
    logic [STAMP_W-1:0] time_value;
    logic [STAMP_W-1:0] time_gap;
    logic [SPILL_W-1:0] spill_out;
    logic               last;

    modport source (
        output valid, kind, channel, count_value, time_value, time_gap, spill_out, last,
        input  ready
    );

    modport sink (
        input  valid, kind, channel, count_value, time_value, time_gap, spill_out, last,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/sru_lane.sv]
// One counter lane: the running sums of every fourth channel and their delta logic.
`default_nettype none

module sru_lane #(
    parameter int NUM_CHANNELS = 32,
    parameter int LANE         = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [sru_pkg::GROUP_W-1:0]  i_row,
    input  logic [sru_pkg::BYTE_W-1:0]   i_raw,
    input  logic                         i_upd,
    input  logic                         i_clr,
    output logic [sru_pkg::BYTE_W-1:0]   o_delta,
    output logic [sru_pkg::COUNT_W-1:0]  o_sum
);
    import sru_pkg::*;

    // This lane owns channels LANE, LANE+4, ... below NUM_CHANNELS.
    localparam int ROWS  = (NUM_CHANNELS - LANE + LANES - 1) / LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [COUNT_W-1:0] r_sum [ROWS];
    logic               w_hit;
    logic [ROW_W-1:0]   w_idx;
    logic [COUNT_W-1:0] w_cur;

    // Rows past the lane's last channel read as zero and are never written.
    assign w_hit = {1'b0, i_row} < (GROUP_W + 1)'(ROWS);
    assign w_idx = i_row[ROW_W-1:0];
    assign w_cur = w_hit ? r_sum[w_idx] : '0;

    // The sum's low byte is the last raw count, so the wrapped delta is a byte subtract.
    assign o_delta = i_raw - w_cur[BYTE_W-1:0];
    assign o_sum   = w_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            for (int r = 0; r < ROWS; r++) begin
                r_sum[r] <= '0;
            end
        end else if (i_upd && w_hit) begin
            r_sum[w_idx] <= w_cur + COUNT_W'(o_delta);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sru_merge.sv]
// Merging stage: picks the lane and timing values for each step and holds the output item.
`default_nettype none

module sru_merge (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sru_pkg::t_step               i_step,
    input  logic [sru_pkg::BYTE_W-1:0]   i_delta [sru_pkg::LANES],
    input  logic [sru_pkg::COUNT_W-1:0]  i_sum [sru_pkg::LANES],
    input  logic [sru_pkg::STAMP_W-1:0]  i_stamp,
    input  logic [sru_pkg::STAMP_W-1:0]  i_base,
    input  logic [sru_pkg::SPILL_W-1:0]  i_spill,
    output logic                         o_load_ok,
    sru_out_if.source                    o_out
);
    import sru_pkg::*;

    logic               r_valid;
    t_kind              r_kind;
    logic [CHAN_W-1:0]  r_channel;
    logic [COUNT_W-1:0] r_count;
    logic [STAMP_W-1:0] r_time;
    logic [STAMP_W-1:0] r_gap;
    logic [SPILL_W-1:0] r_spill;
    logic               r_last;

    logic [LANE_W-1:0]  w_lane;
    logic [COUNT_W-1:0] n_count;
    logic [STAMP_W-1:0] n_time;
    logic [STAMP_W-1:0] n_gap;
    logic [SPILL_W-1:0] n_spill;

    // The output register takes a new item when empty or being emptied.
    assign o_load_ok = !r_valid || o_out.ready;
    assign w_lane    = i_step.channel[LANE_W-1:0];

    // Fill in the fields that belong to the step's kind; the rest stay zero.
    always_comb begin
        n_count = '0;
        n_time  = '0;
        n_gap   = '0;
        n_spill = '0;
        case (i_step.kind)
            KIND_DELTA: begin
                n_count = COUNT_W'(i_delta[w_lane]);
            end
            KIND_SUM: begin
                n_count = i_sum[w_lane];
            end
            KIND_REC, KIND_TRIG: begin
                n_time = i_stamp;
                n_gap  = i_stamp - i_base;
            end
            KIND_SPILL: begin
                n_spill = i_spill;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load_ok) begin
            r_valid <= i_step.load;
            if (i_step.load) begin
                r_kind    <= i_step.kind;
                r_channel <= (i_step.kind == KIND_DELTA || i_step.kind == KIND_SUM)
                             ? i_step.channel : '0;
                r_count   <= n_count;
                r_time    <= n_time;
                r_gap     <= n_gap;
                r_spill   <= n_spill;
                r_last    <= i_step.last;
            end
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_kind;
    assign o_out.channel     = r_channel;
    assign o_out.count_value = r_count;
    assign o_out.time_value  = r_time;
    assign o_out.time_gap    = r_gap;
    assign o_out.spill_out   = r_spill;
    assign o_out.last        = r_last;

endmodule

`default_nettype wire

[hw/rtl/scaler_record_unwrapper.sv]
// Scaler record unwrapper: top level with the result sequencer and four counter lanes.
//
// Each item is one scaler word holding four 8-bit wrapping counters. The four lanes
// compute the wrapped deltas and, for an ordinary word, update the 32-bit channel sums
// in the cycle the item is accepted; the sequencer then issues one result per cycle
// into the output register. An ordinary word issues a delta per channel of the word
// below NUM_CHANNELS, then a record result if it is the record's last word; a word
// whose channels all lie at or above NUM_CHANNELS still passes through the delta walk,
// without a result, before it finishes. A non-final word of a flagged record issues
// no result; an L1-accept last word a trigger result; a spill-end last word a sum per
// channel and a spill-done result (after a trigger result if L1-accept is also set),
// as the dump walks the sums one channel per cycle. The next item is taken as soon as the
// sequencer has handed its last result over, even while that result still waits at the
// output. Back-pressure on the output stalls the sequencer one result at a time.
// Configuration writes (flag bit positions) must only happen while the block is idle.
`default_nettype none

module scaler_record_unwrapper #(
    parameter int NUM_CHANNELS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sru_in_if.sink                        i_in,
    sru_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [sru_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sru_pkg::BIT_W-1:0]     i_cfg_data
);
    import sru_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELTA,
        S_REC,
        S_TRIG,
        S_SUM,
        S_SPILL
    } t_state;

    localparam logic [CHAN_W:0]   NCH     = (CHAN_W + 1)'(NUM_CHANNELS);
    localparam logic [CHAN_W-1:0] LAST_CH = CHAN_W'(NUM_CHANNELS - 1);

    t_state             r_state;
    logic [BIT_W-1:0]   r_l1_bit;
    logic [BIT_W-1:0]   r_se_bit;
    logic [STAMP_W-1:0] r_stamp;
    logic [SPILL_W-1:0] r_spill;
    logic [GROUP_W-1:0] r_group;
    logic               r_last_word;
    logic               r_se;
    logic [LANE_W-1:0]  r_k;
    logic [CHAN_W-1:0]  r_ch;
    logic [STAMP_W-1:0] r_prev_stamp;
    logic [STAMP_W-1:0] r_trig_stamp;
    logic [BYTE_W-1:0]  r_delta [LANES];

    logic               w_accept;
    logic               w_l1;
    logic               w_se;
    logic               w_ord;
    logic [CHAN_W-1:0]  w_dch;
    logic               w_dch_ok;
    logic               w_dch_end;
    logic [GROUP_W-1:0] w_row;
    logic               w_upd;
    logic               w_clr;
    logic               w_load_ok;
    logic               w_fire;
    t_step              w_step;
    logic [STAMP_W-1:0] w_base;
    logic [BYTE_W-1:0]  w_delta [LANES];
    logic [COUNT_W-1:0] w_sum [LANES];

    // Input handshake and flag decode.
    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_l1       = i_in.trigger_flags[r_l1_bit];
    assign w_se       = i_in.trigger_flags[r_se_bit];
    assign w_ord      = !w_l1 && !w_se;

    // Channel of the delta being issued, and whether it is the word's final one.
    assign w_dch     = {r_group, r_k};
    assign w_dch_ok  = {1'b0, w_dch} < NCH;
    assign w_dch_end = (r_k == LANE_W'(LANES - 1))
                       || (({1'b0, w_dch} + (CHAN_W + 1)'(1)) >= NCH);

    // Lanes read the word's row on accept and the dump row while walking the sums.
    assign w_row  = (r_state == S_IDLE) ? i_in.group_index : r_ch[CHAN_W-1:LANE_W];
    assign w_upd  = w_accept && w_ord;
    assign w_fire = w_step.load && w_load_ok;
    assign w_clr  = w_fire && (r_state == S_SPILL);

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        sru_lane #(
            .NUM_CHANNELS (NUM_CHANNELS),
            .LANE         (g)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_row   (w_row),
            .i_raw   (i_in.counter_word[g*BYTE_W +: BYTE_W]),
            .i_upd   (w_upd),
            .i_clr   (w_clr),
            .o_delta (w_delta[g]),
            .o_sum   (w_sum[g])
        );
    end

    // Step offered to the merging stage in each sequencer state.
    always_comb begin
        w_step = '0;
        w_base = r_prev_stamp;
        case (r_state)
            S_DELTA: begin
                w_step.load    = w_dch_ok;
                w_step.kind    = KIND_DELTA;
                w_step.channel = w_dch;
                w_step.last    = w_dch_end && !r_last_word;
            end
            S_REC: begin
                w_step.load = 1'b1;
                w_step.kind = KIND_REC;
                w_step.last = 1'b1;
            end
            S_TRIG: begin
                w_step.load = 1'b1;
                w_step.kind = KIND_TRIG;
                w_step.last = !r_se;
                w_base      = r_trig_stamp;
            end
            S_SUM: begin
                w_step.load    = 1'b1;
                w_step.kind    = KIND_SUM;
                w_step.channel = r_ch;
            end
            S_SPILL: begin
                w_step.load = 1'b1;
                w_step.kind = KIND_SPILL;
                w_step.last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, configuration registers and timing state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_l1_bit     <= BIT_W'(0);
            r_se_bit     <= BIT_W'(1);
            r_k          <= '0;
            r_ch         <= '0;
            r_prev_stamp <= '0;
            r_trig_stamp <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_L1_BIT: r_l1_bit <= i_cfg_data;
                    CFG_SE_BIT: r_se_bit <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_stamp     <= i_in.stamp;
                        r_spill     <= i_in.spill_number;
                        r_group     <= i_in.group_index;
                        r_last_word <= i_in.last_word;
                        r_se        <= w_se;
                        r_delta     <= w_delta;
                        r_k         <= '0;
                        r_ch        <= '0;
                        if (w_ord) begin
                            r_state <= S_DELTA;
                        end else if (i_in.last_word) begin
                            r_state <= w_l1 ? S_TRIG : S_SUM;
                        end
                    end
                end
                S_DELTA: begin
                    // Channels past the last one end the word without a result.
                    if (!w_dch_ok || w_load_ok) begin
                        if (!w_dch_ok || w_dch_end) begin
                            r_state <= r_last_word ? S_REC : S_IDLE;
                        end else begin
                            r_k <= r_k + LANE_W'(1);
                        end
                    end
                end
                S_REC: begin
                    if (w_load_ok) begin
                        r_prev_stamp <= r_stamp;
                        r_state      <= S_IDLE;
                    end
                end
                S_TRIG: begin
                    if (w_load_ok) begin
                        r_trig_stamp <= r_stamp;
                        r_state      <= r_se ? S_SUM : S_IDLE;
                    end
                end
                S_SUM: begin
                    if (w_load_ok) begin
                        if (r_ch == LAST_CH) begin
                            r_state <= S_SPILL;
                        end else begin
                            r_ch <= r_ch + CHAN_W'(1);
                        end
                    end
                end
                S_SPILL: begin
                    if (w_load_ok) begin
                        r_prev_stamp <= '0;
                        r_trig_stamp <= '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    sru_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_delta   (r_delta),
        .i_sum     (w_sum),
        .i_stamp   (r_stamp),
        .i_base    (w_base),
        .i_spill   (r_spill),
        .o_load_ok (w_load_ok),
        .o_out     (o_out)
    );

    // The dump never walks past the last channel.
    a_dump_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> ({1'b0, r_ch} < NCH))
        else $error("sum dump channel out of range");

    // Handing over the spill-done result clears both stored timestamps.
    a_spill_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_step.kind == KIND_SPILL) |=> (r_prev_stamp == '0 && r_trig_stamp == '0))
        else $error("timestamps not cleared after spill end");

    // A new item is never taken while the sequencer still issues results.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !w_step.load)
        else $error("item accepted while results pending");

    // Every spill-done result ends its item.
    a_spill_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step.load && w_step.kind == KIND_SPILL) |-> (w_step.last && r_ch == LAST_CH))
        else $error("spill-done result issued out of order");

endmodule

`default_nettype wire
